// ===== hw/rtl/gms_pkg.sv =====
// Shared codes and types for the gesture motion splitter.
package gms_pkg;

   localparam int DELTA_WIDTH = 16;
   localparam int NUM_SLOTS   = 4;
   localparam int SLOT_IDX_W  = 2;

   localparam logic [1:0] KIND_PRESS   = 2'd0;
   localparam logic [1:0] KIND_MOVE    = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic EV_MOVE    = 1'b0;
   localparam logic EV_RELEASE = 1'b1;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef struct packed {
      logic vld;
      logic pos;   // 1: positive side of the axis (right/down)
   } axis_slot_type;

endpackage

// ===== hw/rtl/gms_axis.sv =====
// One axis: saturating accumulate and split into retraction/extension amounts.
module gms_axis #(
   parameter int ACCUM_WIDTH  = 32,
   parameter int AMOUNT_WIDTH = 16
) (
   input  logic signed [ACCUM_WIDTH-1:0]        acc_old,
   input  logic signed [gms_pkg::DELTA_WIDTH-1:0] delta,
   input  logic                                 en_neg,
   input  logic                                 en_pos,
   output logic signed [ACCUM_WIDTH-1:0]        acc_new,
   output gms_pkg::axis_slot_type               slot0,
   output logic signed [AMOUNT_WIDTH-1:0]       amt0,
   output gms_pkg::axis_slot_type               slot1,
   output logic signed [AMOUNT_WIDTH-1:0]       amt1
);
   import gms_pkg::*;

   localparam int EW = ((ACCUM_WIDTH > AMOUNT_WIDTH) ? ACCUM_WIDTH : AMOUNT_WIDTH) + 1;

   logic signed [ACCUM_WIDTH:0]   sum;
   logic signed [ACCUM_WIDTH-1:0] acc_max;
   logic signed [ACCUM_WIDTH-1:0] acc_min;
   logic signed [EW-1:0]          old_e, now_e, d_e;
   logic signed [EW-1:0]          old_n, now_n, d_n;
   logic                          old_neg, old_pos, now_neg, now_zero, d_zero;
   logic                          s0_vld, s0_pos, s1_vld, s1_pos;

   assign acc_max = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
   assign acc_min = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

   assign sum = {acc_old[ACCUM_WIDTH-1], acc_old}
              + {{(ACCUM_WIDTH+1-DELTA_WIDTH){delta[DELTA_WIDTH-1]}}, delta};

   always_comb begin
      if (sum[ACCUM_WIDTH] != sum[ACCUM_WIDTH-1]) begin
         acc_new = sum[ACCUM_WIDTH] ? acc_min : acc_max;
      end else begin
         acc_new = sum[ACCUM_WIDTH-1:0];
      end
   end

   assign old_e = {{(EW-ACCUM_WIDTH){acc_old[ACCUM_WIDTH-1]}}, acc_old};
   assign now_e = {{(EW-ACCUM_WIDTH){acc_new[ACCUM_WIDTH-1]}}, acc_new};
   assign d_e   = {{(EW-DELTA_WIDTH){delta[DELTA_WIDTH-1]}}, delta};
   assign old_n = -old_e;
   assign now_n = -now_e;
   assign d_n   = -d_e;

   assign old_neg  = acc_old[ACCUM_WIDTH-1];
   assign old_pos  = !old_neg && (acc_old != '0);
   assign now_neg  = acc_new[ACCUM_WIDTH-1];
   assign now_zero = (acc_new == '0);
   assign d_zero   = (delta == '0);

   always_comb begin
      s0_vld = 1'b0;
      s0_pos = 1'b0;
      s1_vld = 1'b0;
      s1_pos = 1'b0;
      amt0   = d_e[AMOUNT_WIDTH-1:0];
      amt1   = now_e[AMOUNT_WIDTH-1:0];
      if (!d_zero) begin
         if (old_neg && !now_neg) begin
            // crossing from the negative side: retract all, extend the rest
            s0_vld = 1'b1;
            s0_pos = 1'b0;
            amt0   = old_e[AMOUNT_WIDTH-1:0];
            s1_vld = !now_zero;
            s1_pos = 1'b1;
            amt1   = now_e[AMOUNT_WIDTH-1:0];
         end else if (old_pos && (now_neg || now_zero)) begin
            s0_vld = 1'b1;
            s0_pos = 1'b1;
            amt0   = old_n[AMOUNT_WIDTH-1:0];
            s1_vld = !now_zero;
            s1_pos = 1'b0;
            amt1   = now_n[AMOUNT_WIDTH-1:0];
         end else if (now_neg) begin
            s0_vld = 1'b1;
            s0_pos = 1'b0;
            amt0   = d_n[AMOUNT_WIDTH-1:0];
         end else if (!now_zero) begin
            s0_vld = 1'b1;
            s0_pos = 1'b1;
            amt0   = d_e[AMOUNT_WIDTH-1:0];
         end
      end
   end

   assign slot0.vld = s0_vld && (s0_pos ? en_pos : en_neg);
   assign slot0.pos = s0_pos;
   assign slot1.vld = s1_vld && (s1_pos ? en_pos : en_neg);
   assign slot1.pos = s1_pos;

endmodule

// ===== hw/rtl/gms_classify.sv =====
// Release classification of the accumulated vector into one cardinal direction.
module gms_classify #(
   parameter int ACCUM_WIDTH = 32
) (
   input  logic signed [ACCUM_WIDTH-1:0] acc_x,
   input  logic signed [ACCUM_WIDTH-1:0] acc_y,
   output logic [1:0]                    direction
);
   import gms_pkg::*;

   logic signed [ACCUM_WIDTH:0] xe, ye, xn, yn;
   logic                        x_neg, y_neg, x_zero;

   assign xe     = {acc_x[ACCUM_WIDTH-1], acc_x};
   assign ye     = {acc_y[ACCUM_WIDTH-1], acc_y};
   assign xn     = -xe;
   assign yn     = -ye;
   assign x_neg  = acc_x[ACCUM_WIDTH-1];
   assign y_neg  = acc_y[ACCUM_WIDTH-1];
   assign x_zero = (acc_x == '0);

   always_comb begin
      if (!x_neg && !y_neg) begin
         direction = (xe >= ye) ? DIR_RIGHT : DIR_DOWN;
      end else if (x_neg && !y_neg) begin
         direction = (xn <= ye) ? DIR_DOWN : DIR_LEFT;
      end else if (x_neg || x_zero) begin
         direction = (xe <= ye) ? DIR_LEFT : DIR_UP;
      end else begin
         direction = (xe <= yn) ? DIR_UP : DIR_RIGHT;
      end
   end

endmodule

// ===== hw/rtl/gesture_motion_splitter.sv =====
// Top level: input register, accumulators, result slots and output register.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+-----------------
//   request  | req_kind, req_delta_x, req_delta_y             | req_valid/ready
//   response | rsp_event_kind, rsp_direction, rsp_amount, ..  | rsp_valid/ready
//   csr      | csr_wr_data                                    | csr_wr_en
//
// A move produces up to four words, a release one, a press none; words leave one per
// cycle while rsp_ready allows, from the single output register draining the four-slot
// result buffer.
// The first word passes the input register, result slots and output register in turn.
// Synchronous reset clears accumulators, valids and sets all directions enabled.
// A stalled output holds its word; input is taken while the last word of the previous
// item drains.
module gesture_motion_splitter #(
   parameter int ACCUM_WIDTH  = 32,
   parameter int AMOUNT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_kind,
   input  logic signed [gms_pkg::DELTA_WIDTH-1:0] req_delta_x,
   input  logic signed [gms_pkg::DELTA_WIDTH-1:0] req_delta_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_event_kind,
   output logic [1:0]                             rsp_direction,
   output logic signed [AMOUNT_WIDTH-1:0]         rsp_amount,
   output logic                                   rsp_last,
   input  logic                                   csr_wr_en,
   input  logic [3:0]                             csr_wr_data
);
   import gms_pkg::*;

   // input register
   logic                          s1_valid_ff;
   logic [1:0]                    s1_kind_ff;
   logic signed [DELTA_WIDTH-1:0] s1_dx_ff, s1_dy_ff;
   logic                          s1_take;

   logic [3:0]                    dir_en_ff;
   logic signed [ACCUM_WIDTH-1:0] acc_x_ff, acc_y_ff, acc_x_in, acc_y_in;
   logic signed [ACCUM_WIDTH-1:0] x_new, y_new;

   axis_slot_type                  x_s0, x_s1, y_s0, y_s1;
   logic signed [AMOUNT_WIDTH-1:0] x_a0, x_a1, y_a0, y_a1;
   logic [1:0]                     rel_dir;

   logic [NUM_SLOTS-1:0]           mask_in;
   logic                           kind_in [NUM_SLOTS];
   logic [1:0]                     dir_in  [NUM_SLOTS];
   logic signed [AMOUNT_WIDTH-1:0] amt_in  [NUM_SLOTS];

   logic [NUM_SLOTS-1:0]           burst_mask_ff;
   logic                           burst_kind_ff [NUM_SLOTS];
   logic [1:0]                     burst_dir_ff  [NUM_SLOTS];
   logic signed [AMOUNT_WIDTH-1:0] burst_amt_ff  [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]           burst_rem;
   logic [SLOT_IDX_W-1:0]          sel;
   logic                           burst_free;

   logic                           out_load;
   logic                           rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [1:0]                     rsp_dir_ff;
   logic signed [AMOUNT_WIDTH-1:0] rsp_amt_ff;

   assign req_ready = !s1_valid_ff || s1_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_kind_ff <= req_kind;
         s1_dx_ff   <= req_delta_x;
         s1_dy_ff   <= req_delta_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_en_ff <= 4'hF;
      end else if (csr_wr_en) begin
         dir_en_ff <= csr_wr_data;
      end
   end

   gms_axis #(.ACCUM_WIDTH(ACCUM_WIDTH), .AMOUNT_WIDTH(AMOUNT_WIDTH)) u_axis_x (
      .acc_old (acc_x_ff),
      .delta   (s1_dx_ff),
      .en_neg  (dir_en_ff[DIR_LEFT]),
      .en_pos  (dir_en_ff[DIR_RIGHT]),
      .acc_new (x_new),
      .slot0   (x_s0),
      .amt0    (x_a0),
      .slot1   (x_s1),
      .amt1    (x_a1)
   );

   gms_axis #(.ACCUM_WIDTH(ACCUM_WIDTH), .AMOUNT_WIDTH(AMOUNT_WIDTH)) u_axis_y (
      .acc_old (acc_y_ff),
      .delta   (s1_dy_ff),
      .en_neg  (dir_en_ff[DIR_UP]),
      .en_pos  (dir_en_ff[DIR_DOWN]),
      .acc_new (y_new),
      .slot0   (y_s0),
      .amt0    (y_a0),
      .slot1   (y_s1),
      .amt1    (y_a1)
   );

   gms_classify #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_classify (
      .acc_x     (acc_x_ff),
      .acc_y     (acc_y_ff),
      .direction (rel_dir)
   );

   // slot order: x retraction/first, x second, y first, y second
   always_comb begin
      mask_in    = '0;
      kind_in[0] = EV_MOVE;
      kind_in[1] = EV_MOVE;
      kind_in[2] = EV_MOVE;
      kind_in[3] = EV_MOVE;
      dir_in[0]  = x_s0.pos ? DIR_RIGHT : DIR_LEFT;
      dir_in[1]  = x_s1.pos ? DIR_RIGHT : DIR_LEFT;
      dir_in[2]  = y_s0.pos ? DIR_DOWN : DIR_UP;
      dir_in[3]  = y_s1.pos ? DIR_DOWN : DIR_UP;
      amt_in[0]  = x_a0;
      amt_in[1]  = x_a1;
      amt_in[2]  = y_a0;
      amt_in[3]  = y_a1;
      acc_x_in   = acc_x_ff;
      acc_y_in   = acc_y_ff;
      case (s1_kind_ff)
         KIND_PRESS: begin
            acc_x_in = '0;
            acc_y_in = '0;
         end
         KIND_MOVE: begin
            mask_in  = {y_s1.vld, y_s0.vld, x_s1.vld, x_s0.vld};
            acc_x_in = x_new;
            acc_y_in = y_new;
         end
         KIND_RELEASE: begin
            mask_in    = {{(NUM_SLOTS-1){1'b0}}, 1'b1};
            kind_in[0] = EV_RELEASE;
            dir_in[0]  = rel_dir;
            amt_in[0]  = '0;
         end
         default: begin
            mask_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (s1_take) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
      end
   end

   // lowest pending slot goes out next
   always_comb begin
      sel = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (burst_mask_ff[i]) begin
            sel = i[SLOT_IDX_W-1:0];
         end
      end
   end

   assign burst_rem  = burst_mask_ff & (burst_mask_ff - 1'b1);
   assign out_load   = !rsp_valid_ff || rsp_ready;
   assign burst_free = (burst_mask_ff == '0) || ((burst_rem == '0) && out_load);
   assign s1_take    = s1_valid_ff && burst_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_mask_ff <= '0;
      end else if (s1_take) begin
         burst_mask_ff <= mask_in;
      end else if (out_load) begin
         burst_mask_ff <= burst_rem;
      end
      if (s1_take) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            burst_kind_ff[i] <= kind_in[i];
            burst_dir_ff[i]  <= dir_in[i];
            burst_amt_ff[i]  <= amt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= (burst_mask_ff != '0);
      end
      if (out_load) begin
         rsp_kind_ff <= burst_kind_ff[sel];
         rsp_dir_ff  <= burst_dir_ff[sel];
         rsp_amt_ff  <= burst_amt_ff[sel];
         rsp_last_ff <= (burst_rem == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_direction  = rsp_dir_ff;
   assign rsp_amount     = rsp_amt_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== hw/rtl/gms_checker.sv =====
// Port-level checks for the gesture motion splitter, bound to the top level.
module gms_checker #(
   parameter int AMOUNT_WIDTH = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_event_kind,
   input logic [1:0]              rsp_direction,
   input logic [AMOUNT_WIDTH-1:0] rsp_amount,
   input logic                    rsp_last
);
   import gms_pkg::*;

   // reset empties the pipeline and opens the input
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // a release word is always the sole word of its item and carries no amount
   a_release_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_RELEASE) |-> rsp_last && (rsp_amount == '0))
      else $error("release word malformed");

   // a stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_direction) && $stable(rsp_amount) && $stable(rsp_last))
      else $error("stalled word changed");

   // a word that follows a non-final word belongs to the same move
   a_burst_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |-> rsp_event_kind == EV_MOVE)
      else $error("release word inside a move burst");

endmodule

bind gesture_motion_splitter gms_checker #(.AMOUNT_WIDTH(AMOUNT_WIDTH)) u_gms_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_kind (rsp_event_kind),
   .rsp_direction  (rsp_direction),
   .rsp_amount     (rsp_amount),
   .rsp_last       (rsp_last)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the gesture motion splitter: directed, random and masked runs.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gms_pkg::*;

   localparam int ACC_W    = 32;
   localparam int AMOUNT_W = 16;
   localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_MIN = -ACC_MAX - 1;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   typedef struct packed {
      logic                event_kind;
      logic [1:0]          direction;
      logic [AMOUNT_W-1:0] amount;
      logic                last;
   } gesture_word_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_kind = KIND_PRESS;
   logic signed [15:0]    req_delta_x = '0;
   logic signed [15:0]    req_delta_y = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_event_kind;
   logic [1:0]            rsp_direction;
   logic signed [AMOUNT_W-1:0] rsp_amount;
   logic                  rsp_last;
   logic                  csr_wr_en = 1'b0;
   logic [3:0]            csr_wr_data = 4'hf;

   // predictor state
   longint           pos_x = 0;
   longint           pos_y = 0;
   logic [3:0]       dir_enable = 4'hf;
   gesture_word_type item_words[$];
   gesture_word_type pending_words[$];
   gesture_word_type head_word;

   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;

   gesture_motion_splitter #(
      .ACCUM_WIDTH (ACC_W),
      .AMOUNT_WIDTH(AMOUNT_W)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_delta_x   (req_delta_x),
      .req_delta_y   (req_delta_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_kind(rsp_event_kind),
      .rsp_direction (rsp_direction),
      .rsp_amount    (rsp_amount),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("** gesture_motion_splitter: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint sat_add(longint a, longint d);
      if (d > 0 && a > ACC_MAX - d) return ACC_MAX;
      if (d < 0 && a < ACC_MIN - d) return ACC_MIN;
      return a + d;
   endfunction

   function automatic void add_amount(logic [1:0] dir, longint amt);
      gesture_word_type w;
      if (!dir_enable[dir]) return;
      w.event_kind = EV_MOVE;
      w.direction  = dir;
      w.amount     = amt[AMOUNT_W-1:0];
      w.last       = 1'b0;
      item_words.push_back(w);
   endfunction

   // crossing zero: full retraction of the old side, then extension of the new one
   function automatic void split_axis(longint old, longint now, longint d,
                                      logic [1:0] neg_dir, logic [1:0] pos_dir);
      if (d == 0) return;
      if (old < 0 && now >= 0) begin
         add_amount(neg_dir, old);
         if (now != 0) add_amount(pos_dir, now);
      end else if (old > 0 && now <= 0) begin
         add_amount(pos_dir, -old);
         if (now != 0) add_amount(neg_dir, -now);
      end else if (now < 0) begin
         add_amount(neg_dir, -d);
      end else if (now > 0) begin
         add_amount(pos_dir, d);
      end
   endfunction

   function automatic logic [1:0] heading(longint x, longint y);
      if (x >= 0 && y >= 0) return (x >= y) ? DIR_RIGHT : DIR_DOWN;
      if (x < 0 && y >= 0) return (-x <= y) ? DIR_DOWN : DIR_LEFT;
      if (x <= 0) return (x <= y) ? DIR_LEFT : DIR_UP;
      return (x <= -y) ? DIR_UP : DIR_RIGHT;
   endfunction

   function automatic void predict_gesture(logic [1:0] kind, logic signed [15:0] dx,
                                           logic signed [15:0] dy);
      gesture_word_type w;
      longint nx;
      longint ny;
      item_words.delete();
      if (kind == KIND_PRESS) begin
         pos_x = 0;
         pos_y = 0;
      end else if (kind == KIND_MOVE) begin
         nx = sat_add(pos_x, longint'(dx));
         ny = sat_add(pos_y, longint'(dy));
         split_axis(pos_x, nx, longint'(dx), DIR_LEFT, DIR_RIGHT);
         split_axis(pos_y, ny, longint'(dy), DIR_UP, DIR_DOWN);
         pos_x = nx;
         pos_y = ny;
      end else if (kind == KIND_RELEASE) begin
         // release ignores the enables
         w.event_kind = EV_RELEASE;
         w.direction  = heading(pos_x, pos_y);
         w.amount     = '0;
         w.last       = 1'b0;
         item_words.push_back(w);
      end
      if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
      foreach (item_words[i]) pending_words.push_back(item_words[i]);
   endfunction

   // ---------------------------------------------------------------- checker

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= recv_idle);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t ns: extra word: expected none, actual kind %0d dir %0d amt %0d last %0d",
                     $time, rsp_event_kind, rsp_direction, rsp_amount, rsp_last);
            errors++;
         end else begin
            head_word = pending_words.pop_front();
            check_field("event_kind", longint'(head_word.event_kind), longint'(rsp_event_kind));
            check_field("direction", longint'(head_word.direction), longint'(rsp_direction));
            check_field("amount", longint'($signed(head_word.amount)), longint'(rsp_amount));
            check_field("last", longint'(head_word.last), longint'(rsp_last));
         end
      end
   end

   // ---------------------------------------------------------------- driver

   task automatic send_word(input logic [1:0] kind, input logic signed [15:0] dx,
                            input logic signed [15:0] dy);
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_delta_x <= dx;
      req_delta_y <= dy;
      do @(posedge clock); while (!req_ready);
      predict_gesture(kind, dx, dy);
   endtask

   // a press leaves no word behind, so allow a few cycles past the last one
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_enable(input logic [3:0] mask);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mask;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      dir_enable = mask;
   endtask

   function automatic logic signed [15:0] pick_delta();
      int v;
      v = $urandom_range(0, 64) - 32;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         1: return '0;
         2, 3, 4, 5: return 16'(v);
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      send_idle = 38;
      recv_idle = 50;
      send_word(KIND_PRESS, 16'h7fff, 16'h8000);
      send_word(KIND_MOVE, 16'h7fff, 16'h8000);     // amount wraps on up
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_MOVE, 16'h8000, 16'h7fff);     // x crosses to the left
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_MOVE, 16'sd1, 16'sd1);         // both axes land on the origin
      send_word(KIND_RELEASE, 16'hffff, 16'hffff);
      send_word(KIND_MOVE, '0, '0);                 // no words at all
      send_word(KIND_MOVE, '0, 16'sd5);
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_MOVE, -16'sd5, '0);            // tie on the down/left diagonal
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_MOVE, -16'sd1, '0);
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_MOVE, 16'sd6, -16'sd11);       // x to origin, y crosses upward
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_MOVE, 16'sd6, '0);             // tie on the up/right diagonal
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_MOVE, 16'sd1, '0);
      send_word(KIND_IGNORED, 16'h8000, 16'h7fff);
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_PRESS, '0, '0);
      send_word(KIND_RELEASE, '0, '0);
      drain();
   endtask

   task automatic test_random_gestures(input int n_items, input int s_idle, input int r_idle);
      int sent;
      int moves;
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int chunk = 0; chunk < 3; chunk++) begin
         set_enable((chunk == 0) ? 4'hf : 4'($urandom_range(0, 15)));
         sent = 0;
         while (sent < n_items / 3) begin
            if ($urandom_range(0, 9) == 0) begin
               send_word(2'($urandom_range(0, 3)), pick_delta(), pick_delta());
               sent++;
            end else begin
               moves = $urandom_range(1, 6);
               send_word(KIND_PRESS, 16'($urandom), 16'($urandom));
               repeat (moves) send_word(KIND_MOVE, pick_delta(), pick_delta());
               send_word(KIND_RELEASE, 16'($urandom), 16'($urandom));
               sent += moves + 2;
            end
         end
      end
      drain();
   endtask

   // masked directions: moves give no words while the release still classifies
   task automatic test_masked_directions();
      send_idle = 0;
      recv_idle = 0;
      set_enable(4'h0);
      send_word(KIND_PRESS, '0, '0);
      send_word(KIND_MOVE, 16'sd3, -16'sd4);
      send_word(KIND_RELEASE, '0, '0);
      repeat (6) send_word(KIND_MOVE, 16'h7fff, 16'h8000);
      send_word(KIND_RELEASE, '0, '0);
      set_enable(4'hf);
      send_word(KIND_MOVE, 16'sd100, -16'sd100);
      send_word(KIND_MOVE, 16'h8000, 16'h7fff);
      send_word(KIND_RELEASE, '0, '0);
      set_enable(4'h0);
      repeat (12) send_word(KIND_MOVE, 16'h8000, 16'h7fff);
      send_word(KIND_RELEASE, '0, '0);
      set_enable(4'hf);
      send_word(KIND_MOVE, -16'sd1, 16'sd1);
      send_word(KIND_MOVE, 16'h7fff, 16'h8000);
      send_word(KIND_RELEASE, '0, '0);
      send_word(KIND_PRESS, '0, '0);
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_gestures(66, 38, 50);
      test_random_gestures(66, 50, 38);
      test_random_gestures(66, 0, 0);
      test_masked_directions();
      drain();
      if (errors == 0) begin
         $display("** gesture_motion_splitter: PASSED **");
      end else begin
         $display("** gesture_motion_splitter: FAILED **");
      end
      $finish;
   end

endmodule
